[design/slcg_pkg.sv]
package slcg_pkg;

    localparam int VAL_W     = 31;
    localparam int SEED_W    = 32;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_MULTIPLIER = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUOTIENT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REMAINDER  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MODULUS    = 3'd3;

    localparam logic [VAL_W-1:0] RST_MULTIPLIER = 31'd16807;
    localparam logic [VAL_W-1:0] RST_QUOTIENT   = 31'd127773;
    localparam logic [VAL_W-1:0] RST_REMAINDER  = 31'd2836;
    localparam logic [VAL_W-1:0] RST_MODULUS    = 31'd2147483647;

    localparam logic CMD_SEED = 1'b0;
    localparam logic CMD_DRAW = 1'b1;

    localparam int WARMUP_STEPS = 40;
    localparam int STEP_W       = $clog2(WARMUP_STEPS);
    localparam int DIV_STEPS    = SEED_W;
    localparam int DIV_CNT_W    = $clog2(DIV_STEPS);

    // table index is last_output / (2^26 + 1)
    localparam int IDX_SHIFT = 26;
    localparam int IDX_W     = VAL_W - IDX_SHIFT;

    localparam int PA_W   = 2 * VAL_W;
    localparam int PR_W   = VAL_W + SEED_W;
    localparam int DIFF_W = 64;

    typedef struct packed {
        logic              load_seed;
        logic              load_draw;
        logic              div_step;
        logic              mul;
        logic              sub;
        logic              fin_seed;
        logic              fin_draw;
        logic              set_last;
        logic              wr_en;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    typedef struct packed {
        logic out_blocked;
    } t_dp_status;

endpackage

[design/slcg_ram.sv]
module slcg_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/slcg_ctrl.sv]
module slcg_ctrl #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    input  logic                    i_command,
    output logic                    o_stall,
    input  slcg_pkg::t_dp_status    i_status,
    output slcg_pkg::t_dp_cmd       o_cmd
);

    import slcg_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_MUL  = 5'b00100,
        S_SUB  = 5'b01000,
        S_FIX  = 5'b10000
    } t_state;

    t_state               r_state, n_state;
    logic                 r_draw, n_draw;
    logic [STEP_W-1:0]    r_step, n_step;
    logic [DIV_CNT_W-1:0] r_div_cnt, n_div_cnt;

    always_comb begin
        n_state   = r_state;
        n_draw    = r_draw;
        n_step    = r_step;
        n_div_cnt = r_div_cnt;
        o_cmd     = '0;
        o_cmd.step = r_step;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_draw    = (i_command == CMD_DRAW);
                    n_step    = STEP_W'(WARMUP_STEPS - 1);
                    n_div_cnt = '0;
                    n_state   = S_DIV;
                    if (i_command == CMD_DRAW) begin
                        o_cmd.load_draw = 1'b1;
                    end else begin
                        o_cmd.load_seed = 1'b1;
                    end
                end
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_div_cnt      = r_div_cnt + 1'b1;
                if (r_div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_SUB;
            end
            S_SUB: begin
                o_cmd.sub = 1'b1;
                n_state   = S_FIX;
            end
            S_FIX: begin
                if (r_draw) begin
                    if (!i_status.out_blocked) begin
                        o_cmd.fin_draw = 1'b1;
                        n_state        = S_IDLE;
                    end
                end else begin
                    o_cmd.fin_seed = 1'b1;
                    o_cmd.wr_en    = (r_step < STEP_W'(TABLE_DEPTH));
                    if (r_step == '0) begin
                        o_cmd.set_last = 1'b1;
                        n_state        = S_IDLE;
                    end else begin
                        n_step    = r_step - 1'b1;
                        n_div_cnt = '0;
                        n_state   = S_DIV;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_draw    <= n_draw;
        r_step    <= n_step;
        r_div_cnt <= n_div_cnt;
    end

    assign o_stall = (r_state != S_IDLE);

endmodule

[design/slcg_dpath.sv]
module slcg_dpath #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  slcg_pkg::t_dp_cmd                i_cmd,
    output slcg_pkg::t_dp_status             o_status,
    input  logic signed [slcg_pkg::SEED_W-1:0] i_seed_value,
    input  logic                             i_cfg_valid,
    input  logic [slcg_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [slcg_pkg::VAL_W-1:0]       i_cfg_data,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic [slcg_pkg::VAL_W-1:0]       o_value
);

    import slcg_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_DEPTH);

    logic [VAL_W-1:0]       r_mult, r_quot, r_rcfg, r_mod;
    logic [VAL_W-1:0]       r_last;
    logic [TABLE_DEPTH-1:0] r_valid;
    logic                   r_out_valid;
    logic [VAL_W-1:0]       r_out;

    logic [SEED_W-1:0]      r_quo;
    logic [VAL_W-1:0]       r_drem;
    logic [PA_W-1:0]        r_pa;
    logic [PR_W-1:0]        r_pr;
    logic [DIFF_W-1:0]      r_diff;
    logic [ADDR_W-1:0]      r_idx;
    logic                   r_pick_valid;

    logic [SEED_W-1:0]      seed_raw, seed_mag;
    logic [VAL_W-1:0]       q_eff;
    logic [SEED_W-1:0]      shifted, shifted_sub;
    logic                   ge;
    logic [IDX_W-1:0]       idx_t, idx_q;
    logic [VAL_W-1:0]       idx_prod;
    logic [ADDR_W-1:0]      idx_addr;
    logic [VAL_W-1:0]       result;
    logic [VAL_W-1:0]       ram_rdata, pick;
    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;

    // seed magnitude, at least one
    always_comb begin
        seed_raw = i_seed_value;
        seed_mag = seed_raw[SEED_W-1] ? (~seed_raw + 1'b1) : seed_raw;
        if (seed_mag == '0) begin
            seed_mag = SEED_W'(1);
        end
    end

    // restoring divider, one quotient bit per cycle
    assign q_eff       = (r_quot == '0) ? VAL_W'(1) : r_quot;
    assign shifted     = {r_drem, r_quo[SEED_W-1]};
    assign ge          = (shifted >= {1'b0, q_eff});
    assign shifted_sub = shifted - {1'b0, q_eff};

    // last_output / (2^26 + 1) is the top bits or one less
    assign idx_t    = r_last[VAL_W-1:IDX_SHIFT];
    assign idx_prod = (VAL_W'(idx_t) << IDX_SHIFT) + VAL_W'(idx_t);
    assign idx_q    = (idx_prod > r_last) ? (idx_t - 1'b1) : idx_t;
    assign idx_addr = ADDR_W'(idx_q);

    assign result = r_diff[DIFF_W-1] ? (r_diff[VAL_W-1:0] + r_mod) : r_diff[VAL_W-1:0];
    assign pick   = r_pick_valid ? ram_rdata : '0;

    assign ram_we    = (i_cmd.fin_seed & i_cmd.wr_en) | i_cmd.fin_draw;
    assign ram_waddr = i_cmd.fin_draw ? r_idx : i_cmd.step[ADDR_W-1:0];

    slcg_ram #(
        .WIDTH (VAL_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (result),
        .i_re    (i_cmd.load_draw),
        .i_raddr (idx_addr),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult      <= RST_MULTIPLIER;
            r_quot      <= RST_QUOTIENT;
            r_rcfg      <= RST_REMAINDER;
            r_mod       <= RST_MODULUS;
            r_last      <= '0;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_MULTIPLIER: r_mult <= i_cfg_data;
                    CFG_QUOTIENT:   r_quot <= i_cfg_data;
                    CFG_REMAINDER:  r_rcfg <= i_cfg_data;
                    CFG_MODULUS:    r_mod  <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (ram_we) begin
                r_valid[ram_waddr] <= 1'b1;
            end
            if (i_cmd.fin_seed && i_cmd.set_last) begin
                r_last <= result;
            end
            if (i_cmd.fin_draw) begin
                r_last      <= pick;
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_seed) begin
            r_quo  <= seed_mag;
            r_drem <= '0;
        end else if (i_cmd.load_draw) begin
            r_quo        <= {1'b0, r_last};
            r_drem       <= '0;
            r_idx        <= idx_addr;
            r_pick_valid <= r_valid[idx_addr];
        end else if (i_cmd.div_step) begin
            r_quo  <= {r_quo[SEED_W-2:0], ge};
            r_drem <= ge ? shifted_sub[VAL_W-1:0] : shifted[VAL_W-1:0];
        end else if (i_cmd.fin_seed) begin
            r_quo  <= {1'b0, result};
            r_drem <= '0;
        end
        if (i_cmd.mul) begin
            r_pa <= PA_W'(r_mult) * PA_W'(r_drem);
            r_pr <= PR_W'(r_rcfg) * PR_W'(r_quo);
        end
        if (i_cmd.sub) begin
            r_diff <= DIFF_W'(r_pa) - DIFF_W'(r_pr);
        end
        if (i_cmd.fin_draw) begin
            r_out <= pick;
        end
    end

    assign o_status.out_blocked = r_out_valid & i_stall;
    assign o_valid              = r_out_valid;
    assign o_value              = r_out;

endmodule

[design/shuffled_lcg_uniform_generator.sv]
// channel   direction  handshake              payload
// input     in         i_valid / o_stall      i_command, i_seed_value
// output    out        o_valid / i_stall      o_value
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// one generator step: bit-serial Schrage division, then multiply, subtract, fix-up
// draw: waits in fix-up while the output is blocked; seed: 40 steps
// one item at a time; o_stall is high from transfer until the item is finished
// a finished draw waits in the output register while i_stall is high
// synchronous active-low reset restores register defaults and an all-zero table
module shuffled_lcg_uniform_generator #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic                                i_command,
    input  logic signed [slcg_pkg::SEED_W-1:0]  i_seed_value,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [slcg_pkg::VAL_W-1:0]          o_value,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [slcg_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [slcg_pkg::VAL_W-1:0]          i_cfg_data
);

    import slcg_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    slcg_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_valid),
        .i_command (i_command),
        .o_stall   (o_stall),
        .i_status  (status),
        .o_cmd     (cmd)
    );

    slcg_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_seed_value (i_seed_value),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_value      (o_value)
    );

    assign o_cfg_ready = 1'b1;

endmodule

[dv/shuffled_lcg_uniform_generator_checker.sv]
module shuffled_lcg_uniform_generator_checker #(
    parameter int TABLE_DEPTH = 32
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    input  logic                                 i_stall_in,
    input  logic                                 i_command,
    input  logic [slcg_pkg::SEED_W-1:0]          i_seed_value,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_stall,
    input  logic [slcg_pkg::VAL_W-1:0]           i_value,
    input  logic                                 i_cfg_valid,
    input  logic                                 i_cfg_ready,
    input  logic [slcg_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [slcg_pkg::VAL_W-1:0]           i_cfg_data,
    output int                                   o_fail_count,
    output int                                   o_pending
);

    import slcg_pkg::*;

    localparam logic [VAL_W-1:0] INDEX_DIVISOR = 31'd67108865;

    logic [VAL_W-1:0] reg_mult;
    logic [VAL_W-1:0] reg_quot;
    logic [VAL_W-1:0] reg_rem;
    logic [VAL_W-1:0] reg_mod;
    logic [VAL_W-1:0] pool [TABLE_DEPTH];
    logic [VAL_W-1:0] prev_draw;
    logic [VAL_W-1:0] expected_draws [$];

    // schrage step, quotient of zero treated as one
    function automatic logic [VAL_W-1:0] schrage_next(input logic [SEED_W:0] x);
        longint unsigned q;
        longint unsigned hi;
        longint unsigned lo;
        longint diff;
        q = (reg_quot == '0) ? 64'd1 : 64'(reg_quot);
        hi = 64'(x) / q;
        lo = 64'(x) - hi * q;
        diff = longint'(64'(reg_mult) * lo) - longint'(64'(reg_rem) * hi);
        if (diff < 0) begin
            diff += longint'(64'(reg_mod));
        end
        return diff[VAL_W-1:0];
    endfunction

    function automatic void fill_pool(input logic [SEED_W-1:0] raw);
        logic [SEED_W:0] s;
        logic [VAL_W-1:0] g;
        s = raw[SEED_W-1] ? {1'b0, ~raw} + 1'b1 : {1'b0, raw};
        if (s == '0) begin
            s = (SEED_W + 1)'(1);
        end
        for (int i = WARMUP_STEPS - 1; i >= 0; i--) begin
            g = schrage_next(s);
            s = {2'b0, g};
            if (i < TABLE_DEPTH) begin
                pool[i] = g;
            end
        end
        prev_draw = pool[0];
    endfunction

    function automatic logic [VAL_W-1:0] draw_from_pool();
        logic [VAL_W-1:0] refill;
        logic [VAL_W-1:0] picked;
        int slot;
        refill = schrage_next({2'b0, prev_draw});
        slot = int'(prev_draw / INDEX_DIVISOR) & (TABLE_DEPTH - 1);
        picked = pool[slot];
        pool[slot] = refill;
        prev_draw = picked;
        return picked;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            reg_mult = RST_MULTIPLIER;
            reg_quot = RST_QUOTIENT;
            reg_rem = RST_REMAINDER;
            reg_mod = RST_MODULUS;
            foreach (pool[k]) begin
                pool[k] = '0;
            end
            prev_draw = '0;
            expected_draws.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (expected_draws.size() == 0) begin
                    $error("value: unexpected result, expected none, actual %0d", i_value);
                    o_fail_count <= o_fail_count + 1;
                end else if (expected_draws[0] !== i_value) begin
                    $error("value mismatch: expected %0d, actual %0d",
                           expected_draws[0], i_value);
                    o_fail_count <= o_fail_count + 1;
                    void'(expected_draws.pop_front());
                end else begin
                    void'(expected_draws.pop_front());
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_MULTIPLIER: reg_mult = i_cfg_data;
                    CFG_QUOTIENT:   reg_quot = i_cfg_data;
                    CFG_REMAINDER:  reg_rem = i_cfg_data;
                    CFG_MODULUS:    reg_mod = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_valid && !i_stall_in) begin
                if (i_command == CMD_SEED) begin
                    fill_pool(i_seed_value);
                end else begin
                    expected_draws = {expected_draws, draw_from_pool()};
                end
            end
        end
        o_pending <= expected_draws.size();
    end

endmodule

[dv/shuffled_lcg_uniform_generator_tb.sv]
module shuffled_lcg_uniform_generator_tb;
    import slcg_pkg::*;

    localparam int STALL_PCT      = 7;
    localparam int MAX_GAP        = 40;
    localparam int SEED_DRAIN     = 1500;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int PHASES         = 8;
    localparam int PHASE_ITEMS    = 175;
    localparam logic [VAL_W-1:0] MOD_MAX = 31'h7FFFFFFF;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       i_valid = 1'b0;
    logic                       o_stall;
    logic                       i_command = CMD_SEED;
    logic signed [SEED_W-1:0]   i_seed_value = '0;
    logic                       o_valid;
    logic                       i_stall = 1'b0;
    logic [VAL_W-1:0]           o_value;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [VAL_W-1:0]           i_cfg_data = '0;

    logic calm = 1'b0;
    int   chk_fail_count;
    int   chk_pending;
    int   quiet_cycles = 0;
    logic [CFG_IDX_W-1:0] cfg_index_q [$];
    logic [VAL_W-1:0]     cfg_data_q [$];

    shuffled_lcg_uniform_generator dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_command    (i_command),
        .i_seed_value (i_seed_value),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_value      (o_value),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    shuffled_lcg_uniform_generator_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_stall_in   (o_stall),
        .i_command    (i_command),
        .i_seed_value (i_seed_value),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_value      (o_value),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (chk_fail_count),
        .o_pending    (chk_pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < STALL_PCT);
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAIL shuffled_lcg_uniform_generator");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send(input logic cmd, input logic [SEED_W-1:0] seed);
        if (!calm && $urandom_range(99) < STALL_PCT) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, MAX_GAP)) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_command <= cmd;
        i_seed_value <= seed;
        do @(posedge i_clk); while (o_stall);
    endtask

    task automatic draws(input int n);
        repeat (n) send(CMD_DRAW, $urandom);
    endtask

    task automatic queue_write(input logic [CFG_IDX_W-1:0] idx, input logic [VAL_W-1:0] data);
        cfg_index_q = {cfg_index_q, idx};
        cfg_data_q = {cfg_data_q, data};
    endtask

    task automatic stage_regs(input logic [VAL_W-1:0] a, q, r, m);
        queue_write(CFG_MULTIPLIER, a);
        queue_write(CFG_QUOTIENT, q);
        queue_write(CFG_REMAINDER, r);
        queue_write(CFG_MODULUS, m);
    endtask

    // a seed in flight gives no result, so drain a full seed time before writing
    task automatic settle_and_configure();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (chk_pending != 0);
        repeat (SEED_DRAIN) @(posedge i_clk);
        while (cfg_index_q.size() > 0) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= cfg_index_q.pop_front();
            i_cfg_data <= cfg_data_q.pop_front();
            do @(posedge i_clk); while (!o_cfg_ready);
        end
        i_cfg_valid <= 1'b0;
    endtask

    function automatic logic [SEED_W-1:0] random_seed();
        logic [SEED_W-1:0] corner_seeds [4] =
            '{32'h80000000, 32'h80000001, 32'h7FFFFFFF, 32'hFFFFFFFF};
        case ($urandom_range(9))
            0: return $urandom_range(3);
            1: return corner_seeds[$urandom_range(3)];
            default: return $urandom;
        endcase
    endfunction

    initial begin
        logic [VAL_W-1:0] a;
        logic [VAL_W-1:0] m;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // draws before any seed see the all-zero table
        draws(2);
        send(CMD_SEED, 32'h00000000);
        draws(3);
        send(CMD_SEED, 32'h00000001);
        draws(1);
        send(CMD_SEED, 32'hFFFFFFFF);
        draws(1);
        send(CMD_SEED, 32'h7FFFFFFF);
        draws(2);
        send(CMD_SEED, 32'h80000001);
        draws(1);
        send(CMD_SEED, 32'h80000000);
        draws(2);
        send(CMD_SEED, 32'h55555555);
        draws(1);
        send(CMD_SEED, 32'hAAAAAAAA);
        draws(1);

        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: stage_regs(31'd48271, 31'd44488, 31'd3399, MOD_MAX);
                1: stage_regs(MOD_MAX - 1, MOD_MAX, MOD_MAX - 1, MOD_MAX);
                2: begin
                    stage_regs(31'd1, 31'd0, 31'd1, 31'd2);
                    for (int k = CFG_MODULUS + 1; k < 2 ** CFG_IDX_W; k++) begin
                        queue_write(CFG_IDX_W'(k), VAL_W'($urandom));
                    end
                end
                3: begin
                    a = VAL_W'($urandom_range(2, 65535));
                    stage_regs(a, MOD_MAX / a, MOD_MAX % a, MOD_MAX);
                end
                4: stage_regs(VAL_W'($urandom_range(1, MOD_MAX - 1)),
                              VAL_W'($urandom_range(1, MOD_MAX)),
                              VAL_W'($urandom_range(0, MOD_MAX - 1)),
                              VAL_W'($urandom_range(2, MOD_MAX)));
                5: begin
                    m = VAL_W'($urandom_range(1 << 20, MOD_MAX));
                    a = VAL_W'($urandom_range(2, 40000));
                    stage_regs(a, m / a, m % a, m);
                end
                6: stage_regs(31'd1, 31'd1, 31'd0, 31'd2);
                default: begin
                    stage_regs(RST_MULTIPLIER, RST_QUOTIENT, RST_REMAINDER, RST_MODULUS);
                    calm <= 1'b1;
                end
            endcase
            settle_and_configure();
            send(CMD_SEED, random_seed());
            for (int n = 1; n < PHASE_ITEMS; n++) begin
                if ($urandom_range(24) == 0) begin
                    send(CMD_SEED, random_seed());
                end else begin
                    send(CMD_DRAW, $urandom);
                end
            end
        end

        settle_and_configure();
        if (chk_fail_count == 0) begin
            $display("PASS shuffled_lcg_uniform_generator");
        end else begin
            $display("FAIL shuffled_lcg_uniform_generator");
        end
        $finish;
    end

endmodule

[filelist.f]
design/slcg_pkg.sv
design/slcg_ram.sv
design/slcg_ctrl.sv
design/slcg_dpath.sv
design/shuffled_lcg_uniform_generator.sv
dv/shuffled_lcg_uniform_generator_checker.sv
dv/shuffled_lcg_uniform_generator_tb.sv
